// ----- hw/rtl/lwe_decrypt_and_rescale_macros.svh -----
// Assertion macros shared by the LWE decrypt-and-rescale RTL.
`ifndef LWE_DECRYPT_AND_RESCALE_MACROS_SVH
`define LWE_DECRYPT_AND_RESCALE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LWEDR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LWEDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition never holds.
`define LWEDR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/lwedr_pkg.sv -----
// Package with types and constants of the LWE decrypt-and-rescale block.
`default_nettype none
package lwedr_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned QUO_W       = WORD_W + FRAC_BITS;
  localparam int unsigned DIV_W       = 62;

  localparam logic [6:0]  PB_RESET  = 7'd32;
  localparam logic [10:0] DIM_RESET = 11'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAINTEXT_BITS     = 3'd0,
    REG_DIMENSION          = 3'd1,
    REG_SIGNAL_MODE        = 3'd2,
    REG_SIGNAL_DIVISOR     = 3'd3,
    REG_RESOLUTION_DIVISOR = 3'd4,
    REG_RESCALE_DIVISOR    = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_WORD = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [6:0]  plaintext_bits;
    logic [10:0] dimension;
    logic        signal_mode;
    logic [30:0] signal_divisor;
    logic [30:0] resolution_divisor;
    logic [30:0] rescale_divisor;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lwedr_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lwedr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lwedr_fifo.sv -----
// Short FIFO between the accumulate front and the divide back.
`default_nettype none
module lwedr_fifo #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lwedr_front.sv -----
// Front end: key loading, multiply-accumulate over ciphertext words, centering.
`default_nettype none
`include "lwe_decrypt_and_rescale_macros.svh"
module lwedr_front #(
  parameter int unsigned KEY_DEPTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lwedr_pkg::cfg_t                cfg_i,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           cmd_i,
  input  wire logic [9:0]                     key_index_i,
  input  wire logic [lwedr_pkg::WORD_W-1:0]   word_i,
  output logic                                q_push_o,
  input  wire logic                           q_full_i,
  output logic      [lwedr_pkg::WORD_W-1:0]   q_data_o
);

  localparam int unsigned AW       = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [2:0]  MAC_LOAD = 3'd0;
  localparam logic [2:0]  MAC_LL   = 3'd1;
  localparam logic [2:0]  MAC_LH   = 3'd2;
  localparam logic [2:0]  MAC_HL   = 3'd3;
  localparam logic [2:0]  MAC_LAST = 3'd4;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MAC,
    F_PUSH
  } state_e;

  state_e      state_q;
  logic [2:0]  step_q;
  logic [10:0] pos_q;
  logic        last_q;
  logic [63:0] acc_q, word_q, key_q, prod_q;

  logic [10:0]   dim_eff;
  logic          accept, last_now;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_rdata;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p, add_term, acc_sum;
  logic [6:0]    pb_eff;
  logic [5:0]    sign_idx;
  logic [63:0]   mask, centered;

  always_comb begin
    if (cfg_i.dimension == '0) begin
      dim_eff = 11'd1;
    end else if (17'(cfg_i.dimension) > 17'(KEY_DEPTH)) begin
      dim_eff = 11'(KEY_DEPTH);
    end else begin
      dim_eff = cfg_i.dimension;
    end
  end

  assign full     = (state_q != F_IDLE);
  assign accept   = push && (state_q == F_IDLE);
  assign last_now = (pos_q >= dim_eff);

  assign ram_we    = accept && (cmd_i == lwedr_pkg::CMD_KEY) &&
                     (17'(key_index_i) < 17'(KEY_DEPTH));
  assign ram_waddr = AW'(key_index_i);
  assign ram_re    = accept && (cmd_i == lwedr_pkg::CMD_WORD) && (pos_q != '0);
  assign ram_raddr = AW'(pos_q - 11'd1);

  lwedr_ram #(
    .WIDTH (lwedr_pkg::WORD_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (word_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign mul_a    = (step_q == MAC_HL) ? key_q[63:32] : key_q[31:0];
  assign mul_b    = (step_q == MAC_LH) ? word_q[63:32] : word_q[31:0];
  assign mul_p    = mul_a * mul_b;
  assign add_term = (step_q == MAC_LH) ? prod_q : {prod_q[31:0], 32'd0};
  assign acc_sum  = acc_q + add_term;

  always_comb begin
    if (cfg_i.plaintext_bits == '0) begin
      pb_eff = 7'd1;
    end else if (cfg_i.plaintext_bits > 7'd64) begin
      pb_eff = 7'd64;
    end else begin
      pb_eff = cfg_i.plaintext_bits;
    end
  end

  assign sign_idx = 6'(pb_eff - 7'd1);
  assign mask     = ~64'd0 >> (7'd64 - pb_eff);
  assign centered = acc_q[sign_idx] ? (acc_q | ~mask) : (acc_q & mask);

  assign q_push_o = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o = centered;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= MAC_LOAD;
      pos_q   <= '0;
      last_q  <= 1'b0;
      acc_q   <= '0;
      word_q  <= '0;
      key_q   <= '0;
      prod_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept && (cmd_i == lwedr_pkg::CMD_WORD)) begin
            pos_q  <= last_now ? '0 : pos_q + 11'd1;
            last_q <= last_now;
            if (pos_q == '0) begin
              acc_q <= word_i;
              if (last_now) begin
                state_q <= F_PUSH;
              end
            end else begin
              word_q  <= word_i;
              step_q  <= MAC_LOAD;
              state_q <= F_MAC;
            end
          end
        end
        F_MAC: begin
          step_q <= step_q + 3'd1;
          if (step_q == MAC_LOAD) begin
            key_q <= ram_rdata;
          end else begin
            prod_q <= mul_p;
          end
          if (step_q >= MAC_LH) begin
            acc_q <= acc_sum;
          end
          if (step_q == MAC_LAST) begin
            state_q <= last_q ? F_PUSH : F_IDLE;
          end
        end
        F_PUSH: begin
          if (!q_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  `LWEDR_ASSERT_NEVER(a_push_when_full, q_push_o && q_full_i, "front pushed into full queue")
  `LWEDR_ASSERT_IMPLIES(a_step_range, state_q == F_MAC, step_q <= MAC_LAST, "MAC step overran")
  `LWEDR_ASSERT_NEXT(a_mac_start, ram_re, (state_q == F_MAC) && (step_q == MAC_LOAD), "MAC not started")

endmodule
`default_nettype wire

// ----- hw/rtl/lwedr_back.sv -----
// Back end: divisor product, restoring division to fixed point, output register.
`default_nettype none
`include "lwe_decrypt_and_rescale_macros.svh"
module lwedr_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire lwedr_pkg::cfg_t                     cfg_i,
  output logic                                     q_pop_o,
  input  wire logic                                q_empty_i,
  input  wire logic        [lwedr_pkg::WORD_W-1:0] q_data_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed      [lwedr_pkg::WORD_W-1:0] plaintext_o,
  output logic signed      [lwedr_pkg::WORD_W-1:0] scaled_value_o
);

  localparam int unsigned QW = lwedr_pkg::QUO_W;
  localparam int unsigned DW = lwedr_pkg::DIV_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_FIN
  } state_e;

  state_e        state_q;
  logic [6:0]    cnt_q;
  logic [63:0]   m_q;
  logic          neg_q;
  logic [QW-1:0] quo_q;
  logic [DW-1:0] rem_q, div_q;
  logic          out_valid_q;

  logic [30:0]   sel_nz, resc_nz, sel_raw;
  logic [DW-1:0] div_prod;
  logic [63:0]   mag_in;
  logic [DW:0]   trial, trial_sub;
  logic          ge;
  logic [63:0]   limit, q_sat, result;
  logic          sat;
  logic          out_load;

  assign sel_raw = cfg_i.signal_mode ? cfg_i.signal_divisor : cfg_i.resolution_divisor;
  assign sel_nz  = (sel_raw == '0) ? 31'd1 : sel_raw;
  assign resc_nz = (cfg_i.rescale_divisor == '0) ? 31'd1 : cfg_i.rescale_divisor;
  assign div_prod = sel_nz * resc_nz;

  assign mag_in    = q_data_i[63] ? (64'd0 - q_data_i) : q_data_i;
  assign trial     = {rem_q, quo_q[QW-1]};
  assign ge        = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  assign limit  = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign sat    = (quo_q > {{lwedr_pkg::FRAC_BITS{1'b0}}, limit});
  assign q_sat  = sat ? limit : quo_q[63:0];
  assign result = neg_q ? (64'd0 - q_sat) : q_sat;

  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i;
  assign empty    = !out_valid_q;
  assign out_load = (state_q == B_FIN) && (!out_valid_q || pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      cnt_q          <= '0;
      m_q            <= '0;
      neg_q          <= 1'b0;
      quo_q          <= '0;
      rem_q          <= '0;
      div_q          <= '0;
      out_valid_q    <= 1'b0;
      plaintext_o    <= '0;
      scaled_value_o <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            m_q     <= q_data_i;
            neg_q   <= q_data_i[63];
            quo_q   <= {mag_in, {lwedr_pkg::FRAC_BITS{1'b0}}};
            rem_q   <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          div_q   <= div_prod;
          cnt_q   <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
          quo_q <= {quo_q[QW-2:0], ge};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(QW - 1)) begin
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          if (out_load) begin
            plaintext_o    <= m_q;
            scaled_value_o <= result;
            state_q        <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  `LWEDR_ASSERT_IMPLIES(a_div_nonzero, state_q == B_DIV, div_q != '0, "zero divisor in divide")
  `LWEDR_ASSERT_IMPLIES(a_cnt_range, state_q == B_DIV, cnt_q < 7'(QW), "divide count overran")
  `LWEDR_ASSERT_NEXT(a_fin_write, (state_q == B_FIN) && !out_valid_q, (state_q == B_IDLE) && out_valid_q, "result not written")

endmodule
`default_nettype wire

// ----- hw/rtl/lwe_decrypt_and_rescale.sv -----
// Top level of the LWE decrypt-and-rescale block: config registers and datapath.
//
// Key words are written with cmd 0. A ciphertext is dimension+1 words with
// cmd 1: the first word loads the accumulator, each later word runs a
// key store read plus three partial products through one shared 32x32
// multiplier, and after the last word the centered sum waits for room in a
// two-entry queue. The divide unit behind that queue takes each ciphertext
// through divisor product, 80-step restoring division, saturate and round
// toward zero, and works while the front accumulates the next ciphertext;
// one output register holds the finished result. The key store has no reset
// and must be written before a ciphertext reads it.
`default_nettype none
module lwe_decrypt_and_rescale #(
  parameter int unsigned KEY_DEPTH = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     push,
  output logic                                          full,
  input  wire logic                                     cmd_i,
  input  wire logic        [9:0]                        key_index_i,
  input  wire logic        [lwedr_pkg::WORD_W-1:0]      word_i,
  output logic                                          empty,
  input  wire logic                                     pop,
  output logic signed      [lwedr_pkg::WORD_W-1:0]      plaintext_o,
  output logic signed      [lwedr_pkg::WORD_W-1:0]      scaled_value_o,
  input  wire logic                                     cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  wire logic        [lwedr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic        [lwedr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  lwedr_pkg::cfg_t              cfg_q;
  logic                         q_push, q_full, q_pop, q_empty;
  logic [lwedr_pkg::WORD_W-1:0] q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plaintext_bits     <= lwedr_pkg::PB_RESET;
      cfg_q.dimension          <= lwedr_pkg::DIM_RESET;
      cfg_q.signal_mode        <= 1'b0;
      cfg_q.signal_divisor     <= 31'd1;
      cfg_q.resolution_divisor <= 31'd1;
      cfg_q.rescale_divisor    <= 31'd1;
    end else if (cfg_valid_i) begin
      unique case (lwedr_pkg::cfg_reg_e'(cfg_index_i))
        lwedr_pkg::REG_PLAINTEXT_BITS:     cfg_q.plaintext_bits     <= cfg_data_i[6:0];
        lwedr_pkg::REG_DIMENSION:          cfg_q.dimension          <= cfg_data_i[10:0];
        lwedr_pkg::REG_SIGNAL_MODE:        cfg_q.signal_mode        <= cfg_data_i[0];
        lwedr_pkg::REG_SIGNAL_DIVISOR:     cfg_q.signal_divisor     <= cfg_data_i[30:0];
        lwedr_pkg::REG_RESOLUTION_DIVISOR: cfg_q.resolution_divisor <= cfg_data_i[30:0];
        lwedr_pkg::REG_RESCALE_DIVISOR:    cfg_q.rescale_divisor    <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  lwedr_front #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .key_index_i (key_index_i),
    .word_i      (word_i),
    .q_push_o    (q_push),
    .q_full_i    (q_full),
    .q_data_o    (q_wdata)
  );

  lwedr_fifo #(
    .WIDTH (lwedr_pkg::WORD_W),
    .DEPTH (lwedr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  lwedr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_pop_o        (q_pop),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rdata),
    .empty          (empty),
    .pop            (pop),
    .plaintext_o    (plaintext_o),
    .scaled_value_o (scaled_value_o)
  );

endmodule
`default_nettype wire
